/* rtl/core/spq_pkg.sv */
// shared types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_FIND   = 2'd2,
        FUNC_RSVD   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_RSVD     = 2'd3
    } t_status;

    // per-cell control, driven by the sequencer in the top level
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the request value
        logic occ;      // cell lies below the fill count
        logic ins;      // insert shift towards the tail
        logic rm;       // remove shift towards the head
    } t_cell_ctl;

endpackage

/* rtl/core/spq_cell.sv */
// one storage cell of the sorted chain: holds a value, compares it locally
// and shifts with its neighbours; depends on spq_pkg
module spq_cell import spq_pkg::*; (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic signed [VALUE_W-1:0] i_prev_data,
    input  logic                      i_prev_le,
    input  logic signed [VALUE_W-1:0] i_next_data,
    output logic signed [VALUE_W-1:0] o_data,
    output logic                      o_le,
    output logic                      o_eq
);

    logic signed [VALUE_W-1:0] r_data;
    logic                      r_le;
    logic                      r_eq;

    // empty cells count as "less or equal" so the boundary exists whenever a cell is empty
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_le <= !i_ctl.occ || (r_data <= i_value);
            r_eq <= i_ctl.occ && (r_data == i_value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && r_le) begin
            r_data <= i_prev_le ? i_prev_data : i_value;
        end else if (i_ctl.rm && r_le) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;
    assign o_le   = r_le;
    assign o_eq   = r_eq;

endmodule

/* rtl/core/spq_locate.sv */
// finds the insert/match boundary in the chain and encodes its index
// depends on spq_pkg
module spq_locate import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0] i_le,
    input  logic [DEPTH-1:0] i_eq,
    output logic             o_found,
    output logic [IW-1:0]    o_index
);

    logic [DEPTH-1:0] bnd;

    // first cell whose value is less or equal marks the boundary
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                bnd[i] = i_le[i];
            end else begin
                bnd[i] = i_le[i] && !i_le[i-1];
            end
        end
    end

    always_comb begin
        o_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (bnd[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end

    assign o_found = |(bnd & i_eq);

endmodule

/* rtl/core/sorted_priority_queue.sv */
// top level of the sorted priority queue: sequencer, cell chain, result register
// depends on spq_pkg, spq_cell and spq_locate
//
// Holds up to DEPTH signed 32-bit values in descending order in a chain of
// cells, largest at the head. A request (func, value) is taken at a rising
// edge with start high and busy low; busy then stays high through the
// compare, update and result states (compare in every cell, boundary decode
// and shift, result capture), and the result beat then appears on the o_
// ports for exactly one cycle with o_strobe high. The receiver cannot stall the
// result, so it must take every beat as it comes. A new request can be taken
// in the same cycle the previous result is shown; while busy is high no new
// request is taken, so each request is finished before the next one starts.
// Stored values need no clearing after reset: only cells below the fill
// count are ever read. Insert into a full queue is refused with status
// full; remove and find with no equal value give status not found, as
// does the unused func code.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_func,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_strobe,
    output logic [1:0]                o_status,
    output logic [3:0]                o_position,
    output logic [4:0]                o_count,
    output logic signed [VALUE_W-1:0] o_head_value,
    output logic                      o_head_valid
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CMP  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_RES  = 4'b1000
    } t_state;

    t_state                    r_state;
    t_func                     r_func;
    logic signed [VALUE_W-1:0] r_value;
    logic [CW-1:0]             r_count;
    logic [1:0]                r_status;
    logic [IW-1:0]             r_pos;
    logic                      r_strobe;
    logic [CW-1:0]             r_out_count;
    logic signed [VALUE_W-1:0] r_head;
    logic                      r_head_valid;

    // chain wiring
    logic signed [VALUE_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]          cell_le;
    logic [DEPTH-1:0]          cell_eq;
    t_cell_ctl                 cell_ctl [DEPTH];

    logic          found;
    logic [IW-1:0] loc_index;
    logic          full;
    logic          do_ins;
    logic          do_rm;

    assign full   = (r_count == FULL_CNT);
    // shift enables only live in the update cycle
    assign do_ins = (r_state == ST_UPD) && (r_func == FUNC_INSERT) && !full;
    assign do_rm  = (r_state == ST_UPD) && (r_func == FUNC_REMOVE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            localparam logic [CW-1:0] CELL_IDX = CW'(gi);
            logic signed [VALUE_W-1:0] prev_data;
            logic                      prev_le;
            logic signed [VALUE_W-1:0] next_data;

            assign cell_ctl[gi].cmp_en = (r_state == ST_CMP);
            assign cell_ctl[gi].occ    = (CELL_IDX < r_count);
            assign cell_ctl[gi].ins    = do_ins;
            assign cell_ctl[gi].rm     = do_rm;

            if (gi == 0) begin : g_head
                // head cell has no upstream neighbour: it takes the new value
                assign prev_data = '0;
                assign prev_le   = 1'b0;
            end else begin : g_mid
                assign prev_data = cell_data[gi-1];
                assign prev_le   = cell_le[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                // tail cell holds its own data on remove, it falls out of range anyway
                assign next_data = cell_data[gi];
            end else begin : g_body
                assign next_data = cell_data[gi+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl[gi]),
                .i_value     (r_value),
                .i_prev_data (prev_data),
                .i_prev_le   (prev_le),
                .i_next_data (next_data),
                .o_data      (cell_data[gi]),
                .o_le        (cell_le[gi]),
                .o_eq        (cell_eq[gi])
            );
        end
    endgenerate

    spq_locate #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_locate (
        .i_le    (cell_le),
        .i_eq    (cell_eq),
        .o_found (found),
        .o_index (loc_index)
    );

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_state <= ST_RES;
                    if (do_ins) begin
                        r_count <= r_count + CW'(1);
                    end else if (do_rm) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                ST_RES: begin
                    r_state  <= ST_IDLE;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // request payload, captured on the accepted beat
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_func  <= t_func'(i_func);
            r_value <= i_value;
        end
    end

    // status and position settle in the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD) begin
            r_pos <= '0;
            case (r_func)
                FUNC_INSERT: begin
                    r_status <= full ? STAT_FULL : STAT_DONE;
                end
                FUNC_REMOVE: begin
                    r_status <= found ? STAT_DONE : STAT_NOTFOUND;
                end
                FUNC_FIND: begin
                    r_status <= found ? STAT_DONE : STAT_NOTFOUND;
                    if (found) begin
                        r_pos <= loc_index;
                    end
                end
                default: begin
                    r_status <= STAT_NOTFOUND;
                end
            endcase
        end
    end

    // result beat, taken from the chain after the shift
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RES) begin
            r_out_count  <= r_count;
            r_head_valid <= (r_count != '0);
            r_head       <= (r_count != '0) ? cell_data[0] : '0;
        end
    end

    logic [IW+3:0] pos_wide;
    logic [CW+4:0] cnt_wide;

    assign pos_wide = {4'b0, r_pos};
    assign cnt_wide = {5'b0, r_out_count};

    assign busy         = (r_state != ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_position   = pos_wide[3:0];
    assign o_count      = cnt_wide[4:0];
    assign o_head_value = r_head;
    assign o_head_valid = r_head_valid;

    // a result beat only follows the result capture cycle
    a_strobe_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == ST_RES))
        else $error("result beat without result capture");

    // fill count stays within the chain
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count beyond depth");

    // a refused insert is only reported on a full chain
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == STAT_FULL) |-> (r_out_count == FULL_CNT))
        else $error("insert refused while not full");

    // count changes only in the update cycle, by one step
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_UPD) |=> $stable(r_count))
        else $error("fill count moved outside update");

endmodule
